>>> rtl/core/bcd_pkg.sv
`timescale 1ns / 1ps

package bcd_pkg;

	// block_format codes; bit 1 set means interpolated alpha
	localparam logic [1:0] FMT_BC1 = 2'd0;
	localparam logic [1:0] FMT_BC2 = 2'd1;

	localparam int unsigned TEXELS = 16;

	typedef struct packed {
		logic [63:0] high_word;
		logic [63:0] low_word;
	} in_t;

	typedef struct packed {
		logic        last_texel;
		logic [31:0] texel_rgba;
		logic [3:0]  texel_index;
	} out_t;

	// one decoded block as handed to the texel stream
	typedef struct packed {
		logic [1:0]        fmt;
		logic              three_mode;
		logic [3:0][23:0]  cpal;
		logic [7:0][7:0]   apal;
		logic [31:0]       idx;
		logic [63:0]       lw;
	} blk_t;

	// RGB565 to 8-bit B,G,R (R in bits 7:0) by bit replication
	function automatic logic [23:0] widen565(input logic [15:0] c);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		r = c[15:11];
		g = c[10:5];
		b = c[4:0];
		return {b, b[4:2], g, g[5:4], r, r[4:2]};
	endfunction

	// x / 3 for x < 768, reciprocal 683 / 2^11
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] p;
		p = 21'(x) * 21'd683;
		return p[18:11];
	endfunction

	// x / 7 for x < 1792, reciprocal 2341 / 2^14
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd2341;
		return p[21:14];
	endfunction

	// x / 5 for x < 1280, reciprocal 3277 / 2^14
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd3277;
		return p[21:14];
	endfunction

endpackage

>>> rtl/core/bc1_bc2_bc3_block_decoder_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Content
// in        in         in_valid/in_ready    one compressed 4x4 block (low_word, high_word)
// out       out        out_valid/out_ready  one texel per request, index 0..15, last marked
// cfg       in         cfg_we               block_format, write only, no wait
//
// On the output side one texel leaves per cycle from the output register unless stalled.
// The first texel passes the input stage, the block register and the output register.
// The next block is taken while the current one streams, so blocks follow with no gap.
// Reset clears all valid flags and sets block_format to BC1.
// A stalled output holds its texel; the stream and the input stage back up behind it.

module bc1_bc2_bc3_block_decoder_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  bcd_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bcd_pkg::out_t out_data
);

	// format register; the user must change it only while the block is idle, the block does not enforce this
	logic [1:0]    format_q;

	// input stage
	logic          valid_s1;
	bcd_pkg::in_t  data_s1;

	logic          bc1;
	logic [63:0]   cw;
	logic          four_mode;
	logic [23:0]   e0;
	logic [23:0]   e1;
	logic [2:0][3:0][7:0] lane_pal;
	logic [7:0][7:0] apal;
	bcd_pkg::blk_t blk;
	logic          blk_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= bcd_pkg::FMT_BC1;
		end else if (cfg_we) begin
			format_q <= cfg_wdata;
		end
	end

	assign in_ready = !valid_s1 || blk_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// BC1 takes colour from the low word and may use three-colour mode
	assign bc1       = (format_q == bcd_pkg::FMT_BC1);
	assign cw        = bc1 ? data_s1.low_word : data_s1.high_word;
	assign four_mode = !bc1 || (cw[15:0] > cw[31:16]);
	assign e0        = bcd_pkg::widen565(cw[15:0]);
	assign e1        = bcd_pkg::widen565(cw[31:16]);

	// one lane per colour channel: R, G, B
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		bcd_colour_lane u_lane (
			.four_mode (four_mode),
			.e0        (e0[ch*8 +: 8]),
			.e1        (e1[ch*8 +: 8]),
			.pal       (lane_pal[ch])
		);
	end

	bcd_alpha_lane u_alpha (
		.a0  (data_s1.low_word[7:0]),
		.a1  (data_s1.low_word[15:8]),
		.pal (apal)
	);

	// gather the lanes into one palette per entry
	always_comb begin
		blk.fmt        = format_q;
		blk.three_mode = !four_mode;
		for (int k = 0; k < 4; k++) begin
			blk.cpal[k] = {lane_pal[2][k], lane_pal[1][k], lane_pal[0][k]};
		end
		blk.apal = apal;
		blk.idx  = cw[63:32];
		blk.lw   = data_s1.low_word;
	end

	bcd_texel_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (valid_s1),
		.blk_ready (blk_ready),
		.blk       (blk),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> rtl/core/bcd_colour_lane.sv
`timescale 1ns / 1ps

// One colour channel: four-entry palette from two widened endpoints.
module bcd_colour_lane (
	input  logic            four_mode,
	input  logic [7:0]      e0,
	input  logic [7:0]      e1,
	output logic [3:0][7:0] pal
);

	logic [9:0] sum2;
	logic [9:0] sum3;
	logic [8:0] half;

	always_comb begin
		sum2 = {e0, 1'b0} + 10'(e1);
		sum3 = 10'(e0) + {e1, 1'b0};
		half = 9'(e0) + 9'(e1);
		pal[0] = e0;
		pal[1] = e1;
		if (four_mode) begin
			pal[2] = bcd_pkg::div3(sum2);
			pal[3] = bcd_pkg::div3(sum3);
		end else begin
			pal[2] = half[8:1];
			pal[3] = 8'd0;
		end
	end

endmodule

>>> rtl/core/bcd_alpha_lane.sv
`timescale 1ns / 1ps

// BC3 alpha palette: sevenths when a0 > a1, else fifths plus 0 and 255.
module bcd_alpha_lane (
	input  logic [7:0]      a0,
	input  logic [7:0]      a1,
	output logic [7:0][7:0] pal
);

	logic            gt;
	logic [5:0][7:0] sev;
	logic [3:0][7:0] fif;

	assign gt = a0 > a1;

	// each entry is independent: weights are fixed per position
	always_comb begin
		for (int i = 1; i < 7; i++) begin
			sev[i-1] = bcd_pkg::div7(11'((7 - i) * 32'(a0) + i * 32'(a1)));
		end
		for (int i = 1; i < 5; i++) begin
			fif[i-1] = bcd_pkg::div5(11'((5 - i) * 32'(a0) + i * 32'(a1)));
		end
		pal[0] = a0;
		pal[1] = a1;
		if (gt) begin
			for (int k = 0; k < 6; k++) begin
				pal[k+2] = sev[k];
			end
		end else begin
			for (int k = 0; k < 4; k++) begin
				pal[k+2] = fif[k];
			end
			pal[6] = 8'd0;
			pal[7] = 8'd255;
		end
	end

endmodule

>>> rtl/core/bcd_texel_merge.sv
`timescale 1ns / 1ps

// Holds one decoded block and streams its texels, one per cycle unless the output stalls.
module bcd_texel_merge (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          blk_valid,
	output logic          blk_ready,
	input  bcd_pkg::blk_t blk,
	output logic          out_valid,
	input  logic          out_ready,
	output bcd_pkg::out_t out_data
);

	logic          busy_q;
	logic [3:0]    cnt_q;
	bcd_pkg::blk_t blk_q;
	logic          out_valid_q;
	bcd_pkg::out_t out_q;

	logic          step;
	logic          last;
	logic          load;
	logic [1:0]    ci;
	logic [5:0]    apos;
	logic [2:0]    ai;
	logic [3:0]    nib;
	logic [7:0]    alpha;
	logic [47:0]   abits;

	assign step      = busy_q && (!out_valid_q || out_ready);
	assign last      = step && (&cnt_q);
	assign blk_ready = !busy_q || last;
	assign load      = blk_valid && blk_ready;

	always_comb begin
		ci    = blk_q.idx[{cnt_q, 1'b0} +: 2];
		abits = blk_q.lw[63:16];
		apos  = {1'b0, cnt_q, 1'b0} + 6'(cnt_q);
		ai    = abits[apos +: 3];
		nib   = blk_q.lw[{cnt_q, 2'b00} +: 4];
		unique case (blk_q.fmt)
			bcd_pkg::FMT_BC1: alpha = (blk_q.three_mode && (&ci)) ? 8'd0 : 8'd255;
			bcd_pkg::FMT_BC2: alpha = {nib, nib};
			default:          alpha = blk_q.apal[ai];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				cnt_q       <= cnt_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (last) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			blk_q <= blk;
		end
		if (step) begin
			out_q.texel_index <= cnt_q;
			out_q.texel_rgba  <= {alpha, blk_q.cpal[ci]};
			out_q.last_texel  <= &cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	// format codes the package leaves out; bit 1 selects interpolated alpha
	localparam logic [1:0] FMT_BC3  = 2'd2;
	localparam logic [1:0] FMT_BC3X = 2'd3;

	// longest run of cycles with no request moving on either channel
	localparam int QUIET_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic          cfg_we = 1'b0;
	logic [1:0]    cfg_wdata = bcd_pkg::FMT_BC1;
	logic          in_valid = 1'b0;
	logic          in_ready;
	bcd_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	bcd_pkg::out_t out_data;

	// texels still owed by the block, oldest first
	bcd_pkg::out_t texels_due [$];

	logic [1:0] cur_fmt = bcd_pkg::FMT_BC1;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int errors = 0;

	always #2 clk = ~clk;

	bc1_bc2_bc3_block_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Decodes one block the way the block should, pushing its 16 texels.
	// Colour word is the low word in BC1, the high word otherwise; only BC1
	// may fall into the three-colour palette (c0 <= c1).
	function automatic void decode_block(input logic [1:0] fmt, input bcd_pkg::in_t blk);
		logic [63:0]  cw;
		logic [15:0]  c0, c1;
		int unsigned  e0 [3];
		int unsigned  e1 [3];
		int unsigned  p2, p3, a0, a1, k;
		logic [23:0]  rgb [4];
		logic [7:0]   calpha [4];
		logic [7:0]   apal [8];
		logic [1:0]   ci;
		logic [7:0]   alpha;
		logic         four;
		bcd_pkg::out_t t;
		cw = (fmt == bcd_pkg::FMT_BC1) ? blk.low_word : blk.high_word;
		c0 = cw[15:0];
		c1 = cw[31:16];
		// bit replication up to 8 bits per channel
		e0[0] = {c0[15:11], c0[15:13]};
		e0[1] = {c0[10:5], c0[10:9]};
		e0[2] = {c0[4:0], c0[4:2]};
		e1[0] = {c1[15:11], c1[15:13]};
		e1[1] = {c1[10:5], c1[10:9]};
		e1[2] = {c1[4:0], c1[4:2]};
		four = (fmt != bcd_pkg::FMT_BC1) || (c0 > c1);
		for (k = 0; k < 3; k++) begin
			if (four) begin
				p2 = (2 * e0[k] + e1[k]) / 3;
				p3 = (e0[k] + 2 * e1[k]) / 3;
			end else begin
				p2 = (e0[k] + e1[k]) / 2;
				p3 = 0;
			end
			rgb[0][8*k +: 8] = 8'(e0[k]);
			rgb[1][8*k +: 8] = 8'(e1[k]);
			rgb[2][8*k +: 8] = 8'(p2);
			rgb[3][8*k +: 8] = 8'(p3);
		end
		calpha[0] = 8'hFF;
		calpha[1] = 8'hFF;
		calpha[2] = 8'hFF;
		calpha[3] = four ? 8'hFF : 8'h00;
		// BC3 alpha palette: sevenths when a0 > a1, else fifths plus 0 and 255
		a0 = blk.low_word[7:0];
		a1 = blk.low_word[15:8];
		apal[0] = 8'(a0);
		apal[1] = 8'(a1);
		if (a0 > a1) begin
			for (k = 1; k < 7; k++)
				apal[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
		end else begin
			for (k = 1; k < 5; k++)
				apal[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
			apal[6] = 8'h00;
			apal[7] = 8'hFF;
		end
		for (k = 0; k < 16; k++) begin
			ci = cw[32 + 2*k +: 2];
			alpha = calpha[ci];
			if (fmt == bcd_pkg::FMT_BC2)
				alpha = 8'(blk.low_word[4*k +: 4] * 17);
			else if (fmt[1])
				alpha = apal[blk.low_word[16 + 3*k +: 3]];
			t.texel_index = 4'(k);
			t.texel_rgba  = {alpha, rgb[ci]};
			t.last_texel  = (k == 15);
			texels_due.push_back(t);
		end
	endfunction

	function automatic bcd_pkg::in_t random_block();
		bcd_pkg::in_t b;
		b.low_word  = {$urandom, $urandom};
		b.high_word = {$urandom, $urandom};
		case ($urandom_range(9))
			0: begin
				// equal colour endpoints in both words
				b.low_word[31:16]  = b.low_word[15:0];
				b.high_word[31:16] = b.high_word[15:0];
			end
			1: b.low_word[15:8] = b.low_word[7:0];
			2: b.low_word[15:0] = {8'h00, 8'hFF};
			3: b.low_word[15:0] = {8'hFF, 8'h00};
			default: ;
		endcase
		return b;
	endfunction

	// Offers one block, waits for the request to be taken, then idles the
	// sender for a random number of cycles.
	task automatic send_block(input bcd_pkg::in_t blk);
		in_valid <= 1'b1;
		in_data  <= blk;
		do @(posedge clk); while (!in_ready);
		decode_block(cur_fmt, blk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Holds the sender until every texel owed has come, then waits extra more cycles.
	task automatic drain(input int extra);
		in_valid <= 1'b0;
		while (texels_due.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Format register is only touched with the block idle.
	task automatic set_format(input logic [1:0] f);
		drain(4);
		cfg_we    <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_fmt = f;
		@(posedge clk);
	endtask

	// Four segments, one per format code, in a rotated order.
	task automatic run_mix(input int per_seg);
		int offs;
		int seg;
		offs = $urandom_range(3);
		for (seg = 0; seg < 4; seg++) begin
			set_format(2'(seg + offs));
			repeat (per_seg) send_block(random_block());
		end
		drain(1);
	endtask

	task automatic test_directed();
		logic [47:0] ramp;
		int i;
		for (i = 0; i < 16; i++)
			ramp[3*i +: 3] = 3'(i);
		send_idle_pct = 0;
		stall_pct = 0;
		set_format(bcd_pkg::FMT_BC1);
		// equal endpoints fall into three-colour mode; high word ignored
		send_block('{high_word: '1, low_word: '0});
		send_block('{high_word: '0, low_word: '1});
		send_block('{high_word: '0, low_word: {32'hE4E4_E4E4, 16'h0000, 16'hFFFF}});
		send_block('{high_word: '1, low_word: {32'hE4E4_E4E4, 16'hFFFF, 16'h0000}});
		send_block('{high_word: '0, low_word: {32'h1B1B_1B1B, 16'h07E0, 16'hF81F}});
		send_block('{high_word: '0, low_word: {32'h4E4E_4E4E, 16'h8410, 16'h8410}});
		set_format(bcd_pkg::FMT_BC2);
		// every nibble value, both endpoint orders, always four colours
		send_block('{high_word: {32'hE4E4_E4E4, 16'h0000, 16'hFFFF},
			low_word: 64'hFEDC_BA98_7654_3210});
		send_block('{high_word: {32'hE4E4_E4E4, 16'hFFFF, 16'h0000},
			low_word: 64'h0123_4567_89AB_CDEF});
		send_block('{high_word: '1, low_word: '1});
		send_block('{high_word: '0, low_word: '0});
		set_format(FMT_BC3);
		// sevenths, fifths and equal alpha endpoints; every alpha index used
		send_block('{high_word: {32'hE4E4_E4E4, 16'h0000, 16'hFFFF},
			low_word: {ramp, 8'h00, 8'hFF}});
		send_block('{high_word: {32'hE4E4_E4E4, 16'h8410, 16'h8410},
			low_word: {ramp, 8'hFF, 8'h00}});
		send_block('{high_word: {32'h1B1B_1B1B, 16'hFFFF, 16'h0000},
			low_word: {ramp, 8'h80, 8'h80}});
		send_block('{high_word: '0, low_word: {~ramp, 8'h13, 8'hC7}});
		send_block('{high_word: '1, low_word: '1});
		send_block('{high_word: '0, low_word: '0});
		set_format(FMT_BC3X);
		send_block('{high_word: {32'hE4E4_E4E4, 16'h0000, 16'hFFFF},
			low_word: {ramp, 8'h00, 8'hFF}});
		send_block('{high_word: '1, low_word: {ramp, 8'hFF, 8'h00}});
		send_block('{high_word: '0, low_word: {~ramp, 8'h42, 8'h42}});
		drain(1);
	endtask

	task automatic test_no_idling();
		send_idle_pct = 0;
		stall_pct = 0;
		run_mix(4);
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 87;
		stall_pct = 0;
		run_mix(4);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		stall_pct = 87;
		run_mix(4);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 35;
		stall_pct = 35;
		run_mix(4);
	endtask

	// Receiver holds off while blocks keep coming, so the input backs up.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		set_format(2'($urandom_range(3)));
		hold_left = 400;
		repeat (12) send_block(random_block());
		drain(1);
	endtask

	// One block at a time, each fully drained before the next.
	task automatic test_drained_sender();
		send_idle_pct = 0;
		stall_pct = 20;
		set_format(2'($urandom_range(3)));
		repeat (6) begin
			send_block(random_block());
			drain(1);
		end
	endtask

	// Receiver: random stalls, or a counted hold-off when one is asked for.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Every texel request is checked against the oldest one owed.
	always @(posedge clk) begin : check_texel
		bcd_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (texels_due.size() == 0) begin
				$display("%0t: unexpected texel, expected none, actual index %0d rgba %08h last %0b",
					$time, out_data.texel_index, out_data.texel_rgba, out_data.last_texel);
				errors++;
			end else begin
				want = texels_due.pop_front();
				if (out_data.texel_index !== want.texel_index) begin
					$display("%0t: texel_index expected %0d actual %0d",
						$time, want.texel_index, out_data.texel_index);
					errors++;
				end
				if (out_data.texel_rgba !== want.texel_rgba) begin
					$display("%0t: texel_rgba (texel %0d) expected %08h actual %08h",
						$time, want.texel_index, want.texel_rgba, out_data.texel_rgba);
					errors++;
				end
				if (out_data.last_texel !== want.last_texel) begin
					$display("%0t: last_texel (texel %0d) expected %0b actual %0b",
						$time, want.texel_index, want.last_texel, out_data.last_texel);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		test_drained_sender();
		// room for any stray texel to show up after the last one owed
		drain(20);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
